>>> design/two_channel_power_up_sequencer_defines.svh
// Assertion macros for the two-channel power-up sequencer.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef TWO_CHANNEL_POWER_UP_SEQUENCER_DEFINES_SVH
`define TWO_CHANNEL_POWER_UP_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
`define TCPUS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCPUS_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCPUS_ASSERT(label, prop, msg)
`define TCPUS_ASSERT_NR(label, prop, msg)
`endif
`endif

>>> design/tcpus_pkg.sv
// Shared types, codes and helpers of the two-channel power-up sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tcpus_pkg;

  localparam int TIMER_W = 16;
  localparam int CFG_W   = 16;
  localparam int LEVEL_W = 8;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam logic [CFG_W-1:0] PFC_SETTLE_RESET   = 16'd400;
  localparam logic [CFG_W-1:0] RELAY_SETTLE_RESET = 16'd150;

  // configuration register indexes
  localparam logic CFG_PFC_SETTLE   = 1'b0;
  localparam logic CFG_RELAY_SETTLE = 1'b1;

  // channel bit sets, also used as regulator mode codes
  localparam logic [1:0] CH_NONE = 2'b00;
  localparam logic [1:0] CH_ONE  = 2'b01;
  localparam logic [1:0] CH_TWO  = 2'b10;
  localparam logic [1:0] CH_BOTH = 2'b11;

  // off command codes
  localparam logic [1:0] OFF_NONE = 2'd0;
  localparam logic [1:0] OFF_CH1  = 2'd1;
  localparam logic [1:0] OFF_CH2  = 2'd2;
  localparam logic [1:0] OFF_ALL  = 2'd3;

  typedef struct packed {
    logic [LEVEL_W-1:0] level_ch1;
    logic [LEVEL_W-1:0] level_ch2;
    logic               system_started;
    logic               output_ok_ch1;
    logic               output_ok_ch2;
    logic               voltage_fault_ch1;
    logic               voltage_fault_ch2;
  } item_t;

  typedef struct packed {
    logic       protection_trip;
    logic       pfc_on_cmd;
    logic [1:0] relay_on_cmd;
    logic [1:0] driver_on_cmd;
    logic [1:0] off_cmd;
    logic [1:0] regulator_mode;
    logic [2:0] sequence_mode;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0] pfc_settle;
    logic [CFG_W-1:0] relay_settle;
  } cfg_t;

  typedef struct packed {
    logic advance;
    logic active;
    logic restart;
  } seq_cmd_t;

  typedef struct packed {
    logic [1:0] relay_bits;
    logic [1:0] driver_on;
    logic       reg_set;
  } seq_stat_t;

  function automatic logic [TIMER_W-1:0] timer_tick(input logic [TIMER_W-1:0] t);
    timer_tick = (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

endpackage

>>> design/tcpus_seq.sv
// Relay / driver / regulator power-up step sequence for one channel mode.
// Depends on tcpus_pkg; instantiated three times by tcpus_ctrl.
`timescale 1ns / 1ps

module tcpus_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  tcpus_pkg::seq_cmd_t           cmd,
  input  logic [1:0]                    chan_bits,
  input  logic [tcpus_pkg::CFG_W-1:0]   settle,
  output tcpus_pkg::seq_stat_t          stat
);

  typedef enum logic [1:0] {
    ST_RELAY  = 2'd0,
    ST_DRIVER = 2'd1,
    ST_REG    = 2'd2,
    ST_DONE   = 2'd3
  } step_t;

  step_t                         step;
  step_t                         step_next;
  logic [tcpus_pkg::TIMER_W-1:0] timer;
  logic [tcpus_pkg::TIMER_W-1:0] timer_next;
  logic [tcpus_pkg::TIMER_W-1:0] elapsed;

  always_comb begin
    elapsed    = tcpus_pkg::timer_tick(timer);
    step_next  = step;
    timer_next = elapsed;
    stat       = '0;
    if (cmd.active) begin
      unique case (step)
        ST_RELAY: begin
          stat.relay_bits = chan_bits;
          timer_next      = '0;
          step_next       = ST_DRIVER;
        end
        ST_DRIVER: begin
          if (elapsed > settle) begin
            stat.driver_on = chan_bits;
            timer_next     = '0;
            step_next      = ST_REG;
          end
        end
        ST_REG: begin
          if (elapsed > settle) begin
            stat.reg_set = 1'b1;
            step_next    = ST_DONE;
          end
        end
        ST_DONE: begin
        end
      endcase
    end
    if (cmd.restart) step_next = ST_RELAY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= ST_RELAY;
      timer <= '0;
    end else if (cmd.advance) begin
      step  <= step_next;
      timer <= timer_next;
    end
  end

endmodule

>>> design/tcpus_ctrl.sv
// Protection check, PFC start and channel mode state machine of the sequencer.
// Depends on tcpus_pkg, tcpus_seq and the assertion macro header.
`timescale 1ns / 1ps
`include "two_channel_power_up_sequencer_defines.svh"

module tcpus_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  tcpus_pkg::item_t    item,
  input  tcpus_pkg::cfg_t     cfg,
  output tcpus_pkg::result_t  res
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_PFC  = 3'd1,
    MODE_BOTH = 3'd2,
    MODE_ONE  = 3'd3,
    MODE_TWO  = 3'd4
  } mode_t;

  mode_t                         mode;
  mode_t                         mode_next;
  mode_t                         mode_eff;
  logic                          pfc_pending;
  logic                          pfc_pending_next;
  logic [tcpus_pkg::TIMER_W-1:0] mode_timer;
  logic [tcpus_pkg::TIMER_W-1:0] mode_timer_next;
  logic [tcpus_pkg::TIMER_W-1:0] mode_timer_eff;
  logic [1:0]                    regulator_select;
  logic [1:0]                    regulator_select_next;

  logic trip, on1, on2, zero1, zero2;
  logic [2:0] restart;
  logic [2:0] active;
  logic [1:0] off;
  logic       pfc_on;

  tcpus_pkg::seq_cmd_t  cmd_both, cmd_one, cmd_two;
  tcpus_pkg::seq_stat_t st_both, st_one, st_two;

  assign on1   = item.level_ch1 > 8'd1;
  assign on2   = item.level_ch2 > 8'd1;
  assign zero1 = item.level_ch1 == '0;
  assign zero2 = item.level_ch2 == '0;
  assign trip  = !item.system_started || !item.output_ok_ch1 || !item.output_ok_ch2 ||
                 item.voltage_fault_ch1 || item.voltage_fault_ch2 || (zero1 && zero2);

  always_comb begin
    mode_eff         = mode;
    mode_timer_eff   = tcpus_pkg::timer_tick(mode_timer);
    pfc_pending_next = pfc_pending;
    if (!trip && (on1 || on2) && pfc_pending) begin
      mode_eff         = MODE_PFC;
      mode_timer_eff   = '0;
      pfc_pending_next = 1'b0;
    end
    mode_next       = mode_eff;
    mode_timer_next = mode_timer_eff;
    restart         = '0;
    active          = '0;
    off             = tcpus_pkg::OFF_NONE;
    pfc_on          = 1'b0;
    if (trip) begin
      mode_next = mode;
      off       = tcpus_pkg::OFF_ALL;
    end else begin
      unique case (mode_eff)
        MODE_PFC: begin
          pfc_on = 1'b1;
          if (mode_timer_eff > cfg.pfc_settle) begin
            if (on1 && on2) begin
              mode_next  = MODE_BOTH;
              restart[0] = 1'b1;
            end else if (on1 && zero2) begin
              mode_next  = MODE_ONE;
              restart[1] = 1'b1;
            end else if (zero1 && on2) begin
              mode_next  = MODE_TWO;
              restart[2] = 1'b1;
            end
            mode_timer_next = '0;
          end
        end
        MODE_BOTH: begin
          active[0] = 1'b1;
          if (on1 && zero2) begin
            off        = tcpus_pkg::OFF_CH2;
            mode_next  = MODE_ONE;
            restart[1] = 1'b1;
          end else if (zero1 && on2) begin
            off        = tcpus_pkg::OFF_CH1;
            mode_next  = MODE_TWO;
            restart[2] = 1'b1;
          end
        end
        MODE_ONE: begin
          active[1] = 1'b1;
          if (on1 && on2) begin
            mode_next  = MODE_BOTH;
            restart[0] = 1'b1;
          end else if (zero1 && on2) begin
            off        = tcpus_pkg::OFF_CH1;
            mode_next  = MODE_TWO;
            restart[2] = 1'b1;
          end
        end
        MODE_TWO: begin
          active[2] = 1'b1;
          if (on1 && on2) begin
            mode_next  = MODE_BOTH;
            restart[0] = 1'b1;
          end else if (on1 && zero2) begin
            off        = tcpus_pkg::OFF_CH2;
            mode_next  = MODE_ONE;
            restart[1] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cmd_both = '{advance: advance, active: active[0], restart: restart[0]};
  assign cmd_one  = '{advance: advance, active: active[1], restart: restart[1]};
  assign cmd_two  = '{advance: advance, active: active[2], restart: restart[2]};

  tcpus_seq u_seq_both (
    .clk(clk), .rst(rst), .cmd(cmd_both), .chan_bits(tcpus_pkg::CH_BOTH),
    .settle(cfg.relay_settle), .stat(st_both)
  );
  tcpus_seq u_seq_one (
    .clk(clk), .rst(rst), .cmd(cmd_one), .chan_bits(tcpus_pkg::CH_ONE),
    .settle(cfg.relay_settle), .stat(st_one)
  );
  tcpus_seq u_seq_two (
    .clk(clk), .rst(rst), .cmd(cmd_two), .chan_bits(tcpus_pkg::CH_TWO),
    .settle(cfg.relay_settle), .stat(st_two)
  );

  always_comb begin
    regulator_select_next = regulator_select;
    if (st_both.reg_set) regulator_select_next = tcpus_pkg::CH_BOTH;
    if (st_one.reg_set)  regulator_select_next = tcpus_pkg::CH_ONE;
    if (st_two.reg_set)  regulator_select_next = tcpus_pkg::CH_TWO;
  end

  assign res.protection_trip = trip;
  assign res.pfc_on_cmd      = pfc_on;
  assign res.relay_on_cmd    = st_both.relay_bits | st_one.relay_bits | st_two.relay_bits;
  assign res.driver_on_cmd   = st_both.driver_on | st_one.driver_on | st_two.driver_on;
  assign res.off_cmd         = off;
  assign res.regulator_mode  = regulator_select_next;
  assign res.sequence_mode   = mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      pfc_pending      <= 1'b1;
      mode_timer       <= '0;
      regulator_select <= tcpus_pkg::CH_NONE;
    end else if (advance) begin
      mode             <= mode_next;
      pfc_pending      <= pfc_pending_next;
      mode_timer       <= mode_timer_next;
      regulator_select <= regulator_select_next;
    end
  end

  `TCPUS_ASSERT(a_trip_holds_mode, advance && trip |=> $stable(mode), "mode moved on a trip")
  `TCPUS_ASSERT_NR(a_one_seq_active, $onehot0(active), "more than one sequence active")
  `TCPUS_ASSERT(a_pfc_entry, advance && pfc_pending && !pfc_pending_next |=> mode == MODE_PFC ||
                mode == MODE_BOTH || mode == MODE_ONE || mode == MODE_TWO,
                "PFC start consumed without leaving idle")
  `TCPUS_ASSERT(a_idle_while_pending, !pfc_pending |-> mode != MODE_IDLE,
                "idle after PFC start")

endmodule

>>> design/two_channel_power_up_sequencer.sv
// Top level of the two-channel power-up sequencer: input and result registers,
// configuration registers. Depends on tcpus_pkg and tcpus_ctrl.
`timescale 1ns / 1ps

// Usage
// s_* channel: one item per millisecond tick with the channel levels, the
//   start flag and the fault flags. m_* channel: one result item per input
//   item, in order, with the trip flag, PFC/relay/driver/off commands, the
//   regulator mode and the sequence mode after that tick.
// cfg_*: write port for the PFC settle ticks (index 0) and the relay settle
//   ticks (index 1); write only while no item is in flight.
// Timing: a result is registered; the input register loads at acceptance and
//   the result register loads when the item moves on from the input register.
//   Throughput: one item per cycle unless m_tready stalls; the sequencer state
//   updates as an item moves from the input register into the result register.
// Reset (rst, synchronous): both registers empty, sequence idle with the PFC
//   start armed, all tick counters zero, settle registers at 400 and 150.
// Stall: while m_tready is low the result is held; one more item can be
//   taken into the input register, after which s_tready drops.

module two_channel_power_up_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // level_ch1[7:0], level_ch2[15:8], system_started[16], output_ok_ch1[17],
  // output_ok_ch2[18], voltage_fault_ch1[19], voltage_fault_ch2[20], zero[23:21]
  input  logic [23:0]                 s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // protection_trip[0], pfc_on_cmd[1], relay_on_cmd[3:2], driver_on_cmd[5:4],
  // off_cmd[7:6], regulator_mode[9:8], sequence_mode[12:10], zero[15:13]
  output logic [15:0]                 m_tdata,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [tcpus_pkg::CFG_W-1:0] cfg_data
);

  logic               in_valid;
  tcpus_pkg::item_t   in_item;
  tcpus_pkg::item_t   s_item;
  logic               out_valid;
  logic [15:0]        out_data;
  logic               out_free;
  logic               advance;
  tcpus_pkg::cfg_t    cfg;
  tcpus_pkg::result_t res;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign s_item.level_ch1         = s_tdata[7:0];
  assign s_item.level_ch2         = s_tdata[15:8];
  assign s_item.system_started    = s_tdata[16];
  assign s_item.output_ok_ch1     = s_tdata[17];
  assign s_item.output_ok_ch2     = s_tdata[18];
  assign s_item.voltage_fault_ch1 = s_tdata[19];
  assign s_item.voltage_fault_ch2 = s_tdata[20];

  tcpus_ctrl u_ctrl (
    .clk(clk), .rst(rst), .advance(advance), .item(in_item), .cfg(cfg), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (out_free) out_valid <= in_valid;
    end
    if (s_tvalid && s_tready) in_item <= s_item;
    if (advance) begin
      out_data <= {3'b000, res.sequence_mode, res.regulator_mode, res.off_cmd,
                   res.driver_on_cmd, res.relay_on_cmd, res.pfc_on_cmd,
                   res.protection_trip};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pfc_settle   <= tcpus_pkg::PFC_SETTLE_RESET;
      cfg.relay_settle <= tcpus_pkg::RELAY_SETTLE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcpus_pkg::CFG_PFC_SETTLE:   cfg.pfc_settle   <= cfg_data;
        tcpus_pkg::CFG_RELAY_SETTLE: cfg.relay_settle <= cfg_data;
      endcase
    end
  end

endmodule
